// ===== hw/rtl/sdtq_pkg.sv =====
`timescale 1ns / 1ps
package sdtq_pkg;
    typedef enum logic [1:0] {
        REQ_ADD_ABS = 2'd0,
        REQ_ADD_REL = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_CANCEL  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_EXPIRED = 3'd0,
        ST_NONE    = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CANCEL  = 3'd4
    } status_t;

    localparam logic [9:0] NS_PER_US = 10'd1000;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        req_t        req;
        logic [63:0] key;
        logic [15:0] tag;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD,
        BK_CHECK,
        BK_CANCEL,
        BK_EMIT
    } bk_state_t;
endpackage

// ===== hw/rtl/sdtq_front.sv =====
`timescale 1ns / 1ps
module sdtq_front
    import sdtq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_now_ns,
    input  logic [63:0] s_deadline_ns,
    input  logic [30:0] s_delay_us,
    input  logic [15:0] s_tag,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    // Stage 1 registers the delay product; stage 2 adds and saturates.
    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [40:0] s1_prod_reg;
    logic        s2_valid_reg;
    cmd_t        s2_cmd_reg;
    logic        adv2;
    logic        adv1;
    logic [64:0] sum;
    logic [63:0] s2_key;

    assign adv2 = !s2_valid_reg || q_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign s_ready = adv1;
    assign q_valid = s2_valid_reg;
    assign q_cmd = s2_cmd_reg;
    assign sum = {1'b0, s1_cmd_reg.key} + {24'd0, s1_prod_reg};
    assign s2_key = (s1_cmd_reg.req == REQ_ADD_REL) ? (sum[64] ? {64{1'b1}} : sum[63:0])
                                                   : s1_cmd_reg.key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= s_valid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
        if (adv1 && s_valid) begin
            s1_cmd_reg.req <= req_t'(s_req_type);
            s1_cmd_reg.tag <= s_tag;
            s1_cmd_reg.key <= (req_t'(s_req_type) == REQ_ADD_ABS) ? s_deadline_ns : s_now_ns;
            s1_prod_reg <= s_delay_us * NS_PER_US;
        end
        if (adv2 && s1_valid_reg) begin
            s2_cmd_reg.req <= s1_cmd_reg.req;
            s2_cmd_reg.tag <= s1_cmd_reg.tag;
            s2_cmd_reg.key <= s2_key;
        end
    end
endmodule

// ===== hw/rtl/sdtq_back.sv =====
`timescale 1ns / 1ps
module sdtq_back
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_tag,
    output logic [4:0]  m_removed_count,
    output logic        m_last
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // Entries are registers each handled at its own slot; one walk step a cycle.
    logic [63:0] dl_reg [DEPTH];
    logic [15:0] tg_reg [DEPTH];
    logic [63:0] dl_next [DEPTH];
    logic [15:0] tg_next [DEPTH];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [4:0]    rm_reg, rm_next;
    cmd_t          cmd_reg, cmd_next;
    bk_state_t     st_reg, st_next;
    logic          ov_reg, ov_next;
    logic [2:0]    ost_reg, ost_next;
    logic [15:0]   otg_reg, otg_next;
    logic [4:0]    orm_reg, orm_next;
    logic          olast_reg, olast_next;
    logic          ret_reg, ret_next;
    logic [IW-1:0] rdi, wri;
    logic [63:0]   rd_dl;
    logic [15:0]   rd_tg;

    assign rdi = rd_reg[IW-1:0];
    assign wri = wr_reg[IW-1:0];
    assign rd_dl = dl_reg[rdi];
    assign rd_tg = tg_reg[rdi];
    assign m_valid = ov_reg;
    assign m_status = ost_reg;
    assign m_out_tag = otg_reg;
    assign m_removed_count = orm_reg;
    assign m_last = olast_reg;
    assign q_ready = (st_reg == BK_IDLE) && !ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BK_IDLE;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
            ret_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
            ret_reg <= ret_next;
        end
        rd_reg <= rd_next;
        wr_reg <= wr_next;
        rm_reg <= rm_next;
        cmd_reg <= cmd_next;
        ost_reg <= ost_next;
        otg_reg <= otg_next;
        orm_reg <= orm_next;
        olast_reg <= olast_next;
        for (int i = 0; i < DEPTH; i++) begin
            dl_reg[i] <= dl_next[i];
            tg_reg[i] <= tg_next[i];
        end
    end

    always_comb begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        rd_next = rd_reg;
        wr_next = wr_reg;
        rm_next = rm_reg;
        cmd_next = cmd_reg;
        ov_next = ov_reg;
        ost_next = ost_reg;
        otg_next = otg_reg;
        orm_next = orm_reg;
        olast_next = olast_reg;
        ret_next = ret_reg;
        for (int i = 0; i < DEPTH; i++) begin
            dl_next[i] = dl_reg[i];
            tg_next[i] = tg_reg[i];
        end
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            BK_IDLE: begin
                if (q_valid && q_ready) begin
                    cmd_next = q_cmd;
                    rm_next = '0;
                    unique case (q_cmd.req)
                        REQ_ADD_ABS, REQ_ADD_REL: begin
                            if (cnt_reg == CW'(DEPTH)) begin
                                ov_next = 1'b1;
                                ost_next = ST_FULL;
                                otg_next = '0;
                                orm_next = '0;
                                olast_next = 1'b1;
                            end else begin
                                // Shift from the tail down toward the insert point.
                                rd_next = cnt_reg;
                                st_next = BK_ADD;
                            end
                        end
                        REQ_CHECK: begin
                            rd_next = '0;
                            st_next = BK_CHECK;
                        end
                        default: begin
                            rd_next = '0;
                            wr_next = '0;
                            st_next = BK_CANCEL;
                        end
                    endcase
                end
            end
            BK_ADD: begin
                if (rd_reg != '0 && dl_reg[IW'(rd_reg - 1'b1)] > cmd_reg.key) begin
                    dl_next[rdi] = dl_reg[IW'(rd_reg - 1'b1)];
                    tg_next[rdi] = tg_reg[IW'(rd_reg - 1'b1)];
                    rd_next = rd_reg - 1'b1;
                end else begin
                    dl_next[rdi] = cmd_reg.key;
                    tg_next[rdi] = cmd_reg.tag;
                    cnt_next = cnt_reg + 1'b1;
                    ov_next = 1'b1;
                    ost_next = ST_ADDED;
                    otg_next = '0;
                    orm_next = '0;
                    olast_next = 1'b1;
                    st_next = BK_EMIT;
                end
            end
            BK_CHECK: begin
                // Count the due prefix, then emit one beat per due entry, or a single none beat if there is none.
                if (rd_reg < cnt_reg && rd_dl <= cmd_reg.key) begin
                    rd_next = rd_reg + 1'b1;
                end else if (rd_reg == '0) begin
                    ov_next = 1'b1;
                    ost_next = ST_NONE;
                    otg_next = '0;
                    orm_next = '0;
                    olast_next = 1'b1;
                    st_next = BK_EMIT;
                end else begin
                    wr_next = rd_reg;
                    rd_next = '0;
                    ret_next = 1'b1;
                    st_next = BK_EMIT;
                end
            end
            BK_CANCEL: begin
                if (rd_reg < cnt_reg) begin
                    if (rd_tg == cmd_reg.tag) begin
                        rm_next = rm_reg + 1'b1;
                    end else begin
                        dl_next[wri] = rd_dl;
                        tg_next[wri] = rd_tg;
                        wr_next = wr_reg + 1'b1;
                    end
                    rd_next = rd_reg + 1'b1;
                end else begin
                    cnt_next = wr_reg;
                    ov_next = 1'b1;
                    ost_next = ST_CANCEL;
                    otg_next = '0;
                    orm_next = rm_reg;
                    olast_next = 1'b1;
                    st_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!ret_reg) begin
                    if (!ov_reg || m_ready) begin
                        st_next = BK_IDLE;
                    end
                end else if (!ov_reg || m_ready) begin
                    if (rd_reg < wr_reg) begin
                        ov_next = 1'b1;
                        ost_next = ST_EXPIRED;
                        otg_next = rd_tg;
                        orm_next = '0;
                        olast_next = (rd_reg + 1'b1 == wr_reg);
                        rd_next = rd_reg + 1'b1;
                    end else begin
                        // Compact: move survivors down by the expired count.
                        ret_next = 1'b0;
                        rd_next = wr_reg;
                        wr_next = '0;
                        st_next = BK_CANCEL;
                        cmd_next.tag = cmd_reg.tag;
                        rm_next = '0;
                    end
                end
            end
            default: st_next = BK_IDLE;
        endcase
        if (st_reg == BK_CANCEL && cmd_reg.req == REQ_CHECK) begin
            // Compaction pass after a check: copy everything, no status beat.
            ov_next = ov_reg && !m_ready;
            ost_next = ost_reg;
            orm_next = orm_reg;
            olast_next = olast_reg;
            otg_next = otg_reg;
            rm_next = rm_reg;
            if (rd_reg < cnt_reg) begin
                dl_next[wri] = rd_dl;
                tg_next[wri] = rd_tg;
                wr_next = wr_reg + 1'b1;
                rd_next = rd_reg + 1'b1;
                st_next = BK_CANCEL;
            end else begin
                cnt_next = wr_reg;
                st_next = BK_EMIT;
            end
        end
    end
endmodule

// ===== hw/rtl/sorted_deadline_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Flow: a request passes both front registers, then an add to a full queue answers
// straight from idle, any other add shifts entries from the tail to its slot, a check
// walks the due prefix and emits a none beat, or one beat per expired entry and then
// compacts, a cancel walks every entry, and every other request ends in the emit state.
// Throughput: one request at a time in the back end, set by the entry walk.
// Reset: a synchronous low on aresetn empties the queue; entries need no clearing.
module sorted_deadline_timer_queue_unit
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_now_ns,
    input  logic [63:0] s_deadline_ns,
    input  logic [30:0] s_delay_us,
    input  logic [15:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_tag,
    output logic [4:0]  m_removed_count,
    output logic        m_last
);
    // The front computes relative deadlines; its two registers form the
    // queue that lets it take new beats while the back end walks entries.
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    sdtq_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_now_ns,
        .s_deadline_ns, .s_delay_us, .s_tag, .q_valid, .q_ready, .q_cmd
    );

    sdtq_back #(.DEPTH(DEPTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready,
        .m_status, .m_out_tag, .m_removed_count, .m_last
    );
endmodule

// ===== hw/rtl/sdtq_checker.sv =====
`timescale 1ns / 1ps
module sdtq_checker
    import sdtq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_out_tag,
    input logic [4:0]  m_removed_count,
    input logic        m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_tag))
        else $error("result beat changed while stalled");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_CANCEL)
        else $error("bad status");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EXPIRED |-> m_last)
        else $error("status beat without last");
    a_tag0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EXPIRED |-> m_out_tag == 16'd0)
        else $error("tag on non-expiry beat");
    a_cnt0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_CANCEL |-> m_removed_count == 5'd0)
        else $error("count on non-cancel beat");
endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_status, .m_out_tag,
    .m_removed_count, .m_last
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import sdtq_pkg::*;

    localparam int DEPTH = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = 2'd0;
    logic [63:0] s_now_ns = 64'd0;
    logic [63:0] s_deadline_ns = 64'd0;
    logic [30:0] s_delay_us = 31'd0;
    logic [15:0] s_tag = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_out_tag;
    logic [4:0]  m_removed_count;
    logic        m_last;

    int error_count = 0;

    // The clock toggles every half period of 5 ns.
    always #5 aclk = ~aclk;

    sorted_deadline_timer_queue_unit #(.DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_now_ns(s_now_ns), .s_deadline_ns(s_deadline_ns),
        .s_delay_us(s_delay_us), .s_tag(s_tag),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_tag(m_out_tag), .m_removed_count(m_removed_count), .m_last(m_last)
    );

    // One response beat as the block should produce it.
    typedef struct packed {
        status_t     status;
        logic [15:0] out_tag;
        logic [4:0]  removed;
        logic        last;
    } timer_beat_t;

    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // The scoreboard keeps its own copy of the sorted queue and the beats
    // that the block still owes.
    class timer_queue_board;
        logic [63:0] dl [$];
        logic [15:0] tg [$];
        timer_beat_t owed [$];

        function void put(status_t st, logic [15:0] t, logic [4:0] r, logic l);
            timer_beat_t b;
            b.status = st;
            b.out_tag = t;
            b.removed = r;
            b.last = l;
            owed.push_back(b);
        endfunction

        function void insert(logic [63:0] d, logic [15:0] t);
            int pos;
            pos = 0;
            if (dl.size() >= DEPTH) begin
                put(ST_FULL, 0, 0, 1'b1);
                return;
            end
            // New entries go behind every entry with an equal deadline.
            while (pos < dl.size() && dl[pos] <= d) pos++;
            dl.insert(pos, d);
            tg.insert(pos, t);
            put(ST_ADDED, 0, 0, 1'b1);
        endfunction

        function void note_request(req_t rq, logic [63:0] now, logic [63:0] d,
                                   logic [30:0] us, logic [15:0] t);
            logic [64:0] sum;
            int n;
            int removed;
            n = 0;
            removed = 0;
            case (rq)
                REQ_ADD_ABS: begin
                    insert(d, t);
                end
                REQ_ADD_REL: begin
                    // The relative deadline saturates instead of wrapping.
                    sum = {1'b0, now} + 65'(us) * 65'(NS_PER_US);
                    insert(sum[64] ? '1 : sum[63:0], t);
                end
                REQ_CHECK: begin
                    while (n < dl.size() && dl[n] <= now) n++;
                    if (n == 0) put(ST_NONE, 0, 0, 1'b1);
                    for (int i = 0; i < n; i++) begin
                        put(ST_EXPIRED, tg[0], 0, i == n - 1);
                        void'(dl.pop_front());
                        void'(tg.pop_front());
                    end
                end
                default: begin
                    for (int i = dl.size() - 1; i >= 0; i--) begin
                        if (tg[i] == t) begin
                            dl.delete(i);
                            tg.delete(i);
                            removed++;
                        end
                    end
                    put(ST_CANCEL, 0, 5'(removed), 1'b1);
                end
            endcase
        endfunction

        function string check_beat(logic [2:0] st, logic [15:0] t, logic [4:0] r,
                                   logic l);
            timer_beat_t e;
            if (owed.size() == 0) return "beat with nothing expected";
            e = owed.pop_front();
            if (st !== e.status || t !== e.out_tag || r !== e.removed || l !== e.last)
                return $sformatf("got st %0d tag %0h rem %0d last %0d, want %0d %0h %0d %0d",
                                 st, t, r, l, e.status, e.out_tag, e.removed, e.last);
            return "";
        endfunction
    endclass

    timer_queue_board board = new();

    // A handful of tags and times keeps collisions frequent, so that equal
    // deadlines and multi-entry cancels are common.
    logic [15:0] tag_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

    // Valid stays up after an accepted beat until the next send either loads
    // a new payload at once or drops it for an idle stretch.
    task automatic send(req_t rq, logic [63:0] now, logic [63:0] d,
                        logic [30:0] us, logic [15:0] t);
        int idle;
        idle = $urandom_range(0, 9);
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rq;
        s_now_ns <= now;
        s_deadline_ns <= d;
        s_delay_us <= us;
        s_tag <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(rq, now, d, us, t);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
    endtask

    // The receiver stalls a random number of cycles before each beat, with
    // occasional stretches of constant readiness.
    initial begin : result_side
        string msg;
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            msg = board.check_beat(m_status, m_out_tag, m_removed_count, m_last);
            if (msg != "") report(msg);
        end
    end

    initial begin : stimulus
        logic [63:0] clock_ns;
        int kind;
        clock_ns = 64'd5000;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty check, zero-match cancel, equal deadlines, extremes.
        send(REQ_CHECK, 64'd0, 64'd0, 31'd0, 16'h0000);
        send(REQ_CANCEL, 64'd0, 64'd0, 31'd0, 16'hFFFF);
        send(REQ_ADD_ABS, 64'd0, 64'd100, 31'd0, 16'h0001);
        send(REQ_ADD_ABS, 64'd0, 64'd100, 31'd0, 16'h0002);
        send(REQ_ADD_ABS, 64'd0, 64'd0, 31'd0, 16'hFFFF);
        send(REQ_ADD_ABS, 64'd0, '1, 31'd0, 16'h0003);
        send(REQ_ADD_REL, '1, 64'd0, 31'h7FFFFFFF, 16'h0004);
        send(REQ_ADD_REL, 64'd7, 64'd0, 31'd0, 16'h0005);
        send(REQ_ADD_REL, 64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA,
             31'h5555_5555, 16'hAAAA);
        send(REQ_CHECK, 64'd100, 64'd0, 31'd0, 16'h0000);
        send(REQ_CANCEL, 64'd0, 64'd0, 31'd0, 16'h0003);
        for (int i = 0; i < DEPTH + 2; i++)
            send(REQ_ADD_ABS, 64'd0, 64'(i % 5) * 64'd1000, 31'd0, tag_pool[i % 4]);
        send(REQ_CANCEL, 64'd0, 64'd0, 31'd0, 16'hFFFF);
        send(REQ_CHECK, '1, 64'd0, 31'd0, 16'h0000);

        // The sender waits here until every owed beat has come back.
        drain();

        // Random: mostly well-ordered time with occasional wild values.
        for (int n = 0; n < 250; n++) begin
            clock_ns = clock_ns + 64'($urandom_range(0, 3000));
            kind = $urandom_range(0, 9);
            if (kind < 4)
                send(REQ_ADD_ABS, clock_ns, clock_ns + 64'($urandom_range(0, 8000)),
                     31'($urandom), tag_pool[$urandom_range(0, 3)]);
            else if (kind < 6)
                send(REQ_ADD_REL, clock_ns, {$urandom, $urandom},
                     31'($urandom_range(0, 8)), tag_pool[$urandom_range(0, 3)]);
            else if (kind < 8)
                send(REQ_CHECK, clock_ns, {$urandom, $urandom}, 31'($urandom),
                     16'($urandom));
            else if (kind == 8)
                send(REQ_CANCEL, clock_ns, {$urandom, $urandom}, 31'($urandom),
                     ($urandom_range(0, 1) == 0) ? tag_pool[$urandom_range(0, 3)]
                                                 : 16'($urandom));
            else
                send(req_t'($urandom_range(0, 3)), {$urandom, $urandom},
                     {$urandom, $urandom}, 31'($urandom), 16'($urandom));
            if (n == 120) drain();
        end

        drain();
        repeat (3 * DEPTH + 20) @(posedge aclk);
        if (error_count == 0 && board.owed.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #3ms;
        $display("tb: done, errors");
        $finish;
    end
endmodule
